>>> hw/rtl/sstf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-first head scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int SECTOR_W = 16;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;

  // Head travel per tick, in sectors.
  localparam int SEEK_STEP = 5;

  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEEK_GO   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEEK_DONE = 2'd3;

  typedef struct packed {
    logic                func;
    logic [SECTOR_W-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SECTOR_W-1:0] target;
    logic [SECTOR_W-1:0] from_sector;
    logic [TIME_W-1:0]   now;
    logic                last;
  } out_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/sstf_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_slot_table
// Request slot table: valid bits in flops, sectors in a synchronous memory,
// and a one-entry-per-cycle scan that finds the waiting sector nearest the
// head, with ties going to the lowest slot.
// ----------------------------------------------------------------------------
module sstf_slot_table #(
  parameter int DEPTH       = 16,
  parameter int SECTOR_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   ins_en,
  input  wire logic [SECTOR_BITS-1:0] ins_sector,
  output logic                        full,
  output logic                        any_valid,
  input  wire logic                   scan_start,
  input  wire logic [SECTOR_BITS-1:0] head_pos,
  output logic                        scan_done,
  output logic [SECTOR_BITS-1:0]      best_sector,
  output logic [SECTOR_BITS-1:0]      best_dist,
  input  wire logic                   take_en
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [SECTOR_BITS-1:0] mem [DEPTH];

  logic [DEPTH-1:0]       valid_r, valid_nxt;
  logic [IDX_W-1:0]       free_idx;

  logic                   issue_r, cmp_vld_r, cmp_last_r, done_r, found_r;
  logic [IDX_W-1:0]       addr_r, cmp_idx_r, best_idx_r;
  logic [SECTOR_BITS-1:0] rd_data_r, best_sector_r, best_dist_r;
  logic [SECTOR_BITS-1:0] cand_dist;
  logic                   cand_hit, cand_better;

  assign full      = &valid_r;
  assign any_valid = |valid_r;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ins_en && !full) valid_nxt[free_idx] = 1'b1;
    if (take_en) valid_nxt[best_idx_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ins_en && !full) mem[free_idx] <= ins_sector;
    if (issue_r) rd_data_r <= mem[addr_r];
  end

  assign cand_dist   = (rd_data_r >= head_pos) ? (rd_data_r - head_pos)
                                               : (head_pos - rd_data_r);
  assign cand_hit    = cmp_vld_r && valid_r[cmp_idx_r];
  // Strict compare keeps the earlier, lower slot on a tie.
  assign cand_better = cand_hit && (!found_r || (cand_dist < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      issue_r    <= 1'b0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      done_r     <= 1'b0;
      found_r    <= 1'b0;
      addr_r     <= '0;
      cmp_idx_r  <= '0;
    end else begin
      valid_r    <= valid_nxt;
      done_r     <= cmp_vld_r && cmp_last_r;
      cmp_vld_r  <= issue_r;
      cmp_idx_r  <= addr_r;
      cmp_last_r <= (addr_r == LAST_IDX);
      if (scan_start) begin
        issue_r <= 1'b1;
        addr_r  <= '0;
        found_r <= 1'b0;
      end else begin
        if (issue_r) begin
          if (addr_r == LAST_IDX) begin
            issue_r <= 1'b0;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        if (cand_better) found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_better) begin
      best_idx_r    <= cmp_idx_r;
      best_sector_r <= rd_data_r;
      best_dist_r   <= cand_dist;
    end
  end

  assign scan_done   = done_r;
  assign best_sector = best_sector_r;
  assign best_dist   = best_dist_r;

endmodule
`default_nettype wire

>>> hw/rtl/sstf_disk_head_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_disk_head_scheduler_unit
// Shortest-seek-first disk head scheduler: takes request arrivals and time
// ticks, and reports accepted or dropped arrivals, seek starts and seek
// completions.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                 Transfer
//   -------  --------------------  ----------------------------------------
//   input    start, busy, in_data  edge with start high and busy low
//   result   out_valid, out_data   each cycle with out_valid high
//
// An item with no seek to start passes through ST_IDLE and ST_SCHED. Each seek
// started adds a full scan of the slot memory, one entry per cycle, in ST_SCAN;
// a seek shorter than one step also passes through ST_DONE, which reports the
// completion, and back through ST_SCHED, which looks for the next request.
// Results leave from an output register, one per cycle, and cannot be held
// off. Reset is synchronous and empties the slot table at once through its
// valid flops; the head, time and seek state return to zero.
// ----------------------------------------------------------------------------
module sstf_disk_head_scheduler_unit #(
  parameter int DEPTH       = 16,
  parameter int SECTOR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sstf_pkg::in_item_t in_data,
  output logic                    out_valid,
  output sstf_pkg::out_item_t     out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCHED = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [SECTOR_BITS-1:0] STEP = SECTOR_BITS'(sstf_pkg::SEEK_STEP);

  logic [1:0]                      state_r, state_nxt;
  logic                            seek_busy_r, seek_busy_nxt;
  logic [SECTOR_BITS-1:0]          rem_r, rem_nxt;
  logic [SECTOR_BITS-1:0]          active_r, active_nxt;
  logic [SECTOR_BITS-1:0]          head_r, head_nxt;
  logic [sstf_pkg::TIME_W-1:0]     time_r, time_nxt;
  logic                            out_valid_r, out_valid_nxt;
  sstf_pkg::out_item_t             out_r, out_nxt;

  logic                            accept;
  logic [SECTOR_BITS-1:0]          in_sector;
  logic [SECTOR_BITS-1:0]          rem_dec;
  logic                            ins_en, scan_start, take_en;
  logic                            full, any_valid, scan_done;
  logic [SECTOR_BITS-1:0]          best_sector, best_dist;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_sector = SECTOR_BITS'(in_data.sector);
  assign rem_dec   = rem_r - STEP;

  sstf_slot_table #(
    .DEPTH       (DEPTH),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_slots (
    .clk         (clk),
    .rst_n       (rst_n),
    .ins_en      (ins_en),
    .ins_sector  (in_sector),
    .full        (full),
    .any_valid   (any_valid),
    .scan_start  (scan_start),
    .head_pos    (head_r),
    .scan_done   (scan_done),
    .best_sector (best_sector),
    .best_dist   (best_dist),
    .take_en     (take_en)
  );

  always_comb begin
    state_nxt     = state_r;
    seek_busy_nxt = seek_busy_r;
    rem_nxt       = rem_r;
    active_nxt    = active_r;
    head_nxt      = head_r;
    time_nxt      = time_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ins_en        = 1'b0;
    scan_start    = 1'b0;
    take_en       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCHED;
          if (in_data.func == sstf_pkg::FUNC_ARRIVAL) begin
            ins_en                = 1'b1;
            out_valid_nxt         = 1'b1;
            out_nxt.kind          = full ? sstf_pkg::KIND_DROPPED
                                         : sstf_pkg::KIND_ACCEPTED;
            out_nxt.target        = sstf_pkg::SECTOR_W'(in_sector);
            out_nxt.from_sector   = sstf_pkg::SECTOR_W'(head_r);
            out_nxt.now           = time_r;
            // The table holds at least one request now, so only a seek in
            // flight keeps the scheduler from adding results.
            out_nxt.last          = seek_busy_r;
          end else begin
            time_nxt = time_r + 1'b1;
            if (seek_busy_r) begin
              // A busy seek always has at least one tick left.
              rem_nxt = rem_dec;
              if (rem_dec < STEP) begin
                seek_busy_nxt       = 1'b0;
                head_nxt            = active_r;
                out_valid_nxt       = 1'b1;
                out_nxt.kind        = sstf_pkg::KIND_SEEK_DONE;
                out_nxt.target      = sstf_pkg::SECTOR_W'(active_r);
                out_nxt.from_sector = sstf_pkg::SECTOR_W'(head_r);
                out_nxt.now         = time_r + 1'b1;
                out_nxt.last        = !any_valid;
              end
            end
          end
        end
      end
      ST_SCHED: begin
        if (seek_busy_r || !any_valid) begin
          state_nxt = ST_IDLE;
        end else begin
          scan_start = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          take_en             = 1'b1;
          active_nxt          = best_sector;
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = sstf_pkg::KIND_SEEK_GO;
          out_nxt.target      = sstf_pkg::SECTOR_W'(best_sector);
          out_nxt.from_sector = sstf_pkg::SECTOR_W'(head_r);
          out_nxt.now         = time_r;
          out_nxt.last        = (best_dist >= STEP);
          if (best_dist >= STEP) begin
            seek_busy_nxt = 1'b1;
            rem_nxt       = best_dist;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Seek shorter than one step: completes at the time value it started at.
        head_nxt            = active_r;
        out_valid_nxt       = 1'b1;
        out_nxt.kind        = sstf_pkg::KIND_SEEK_DONE;
        out_nxt.target      = sstf_pkg::SECTOR_W'(active_r);
        out_nxt.from_sector = sstf_pkg::SECTOR_W'(head_r);
        out_nxt.now         = time_r;
        out_nxt.last        = !any_valid;
        state_nxt           = ST_SCHED;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seek_busy_r <= 1'b0;
      rem_r       <= '0;
      active_r    <= '0;
      head_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seek_busy_r <= seek_busy_nxt;
      rem_r       <= rem_nxt;
      active_r    <= active_nxt;
      head_r      <= head_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-seek-first head scheduler. A directed
// opening fills the slot table behind a long seek, forces a drop, releases a
// 33-result cascade and checks tie breaking. Random arrivals and ticks follow,
// mostly close to the head. Every result is compared field by field with a
// scoreboard that keeps its own copy of the scheduler state.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SEC_W       = sstf_pkg::SECTOR_W;
  localparam int SLOTS       = 16;
  localparam int SEC_MAX     = (1 << SEC_W) - 1;
  localparam int NUM_ITEMS   = 350;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  class seek_scoreboard;
    logic [SEC_W-1:0]            head_at;
    logic                        head_busy;
    int                          seek_remaining;
    logic [SEC_W-1:0]            active_target;
    logic                        slot_used[SLOTS];
    logic [SEC_W-1:0]            slot_sector[SLOTS];
    logic [sstf_pkg::TIME_W-1:0] clock_now;
    sstf_pkg::out_item_t         pending_events[$];
    int                          n_arrivals, n_dropped, n_ticks, n_done, n_checked, errors;

    function new();
      head_at        = '0;
      head_busy      = 1'b0;
      seek_remaining = 0;
      active_target  = '0;
      clock_now      = '0;
      foreach (slot_used[i]) begin
        slot_used[i]   = 1'b0;
        slot_sector[i] = '0;
      end
      n_arrivals = 0;
      n_dropped  = 0;
      n_ticks    = 0;
      n_done     = 0;
      n_checked  = 0;
      errors     = 0;
    endfunction

    function void push_event(logic [sstf_pkg::KIND_W-1:0] kind, logic [SEC_W-1:0] tgt);
      sstf_pkg::out_item_t e;
      e.kind        = kind;
      e.target      = tgt;
      e.from_sector = head_at;
      e.now         = clock_now;
      e.last        = 1'b0;
      pending_events = {pending_events, e};
    endfunction

    // The completion reports the seek origin, then the head moves.
    function void finish_seek();
      push_event(sstf_pkg::KIND_SEEK_DONE, active_target);
      head_at   = active_target;
      head_busy = 1'b0;
      n_done++;
    endfunction

    // Start nearest waiting requests until the head is busy or none remain.
    function void dispatch();
      int best;
      int best_dist;
      int d;
      while (!head_busy) begin
        best      = -1;
        best_dist = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) begin
            d = (slot_sector[i] >= head_at) ? int'(slot_sector[i]) - int'(head_at)
                                             : int'(head_at) - int'(slot_sector[i]);
            if (best < 0 || d < best_dist) begin
              best      = i;
              best_dist = d;
            end
          end
        end
        if (best < 0) break;
        slot_used[best] = 1'b0;
        active_target   = slot_sector[best];
        seek_remaining  = best_dist / sstf_pkg::SEEK_STEP;
        head_busy       = 1'b1;
        push_event(sstf_pkg::KIND_SEEK_GO, active_target);
        if (seek_remaining == 0) finish_seek();
      end
    endfunction

    function void log_request(sstf_pkg::in_item_t it);
      int n0;
      int free_slot;
      n0        = pending_events.size();
      free_slot = -1;
      if (it.func == sstf_pkg::FUNC_ARRIVAL) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_used[free_slot]   = 1'b1;
          slot_sector[free_slot] = it.sector;
          push_event(sstf_pkg::KIND_ACCEPTED, it.sector);
          n_arrivals++;
        end else begin
          push_event(sstf_pkg::KIND_DROPPED, it.sector);
          n_dropped++;
        end
      end else begin
        clock_now = clock_now + 1'b1;
        n_ticks++;
        if (head_busy) begin
          if (seek_remaining > 0) seek_remaining--;
          if (seek_remaining == 0) finish_seek();
        end
      end
      dispatch();
      if (pending_events.size() > n0)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(sstf_pkg::out_item_t got);
      sstf_pkg::out_item_t want;
      n_checked++;
      if (pending_events.size() == 0) begin
        $error("unexpected result: kind %0d target %0d now %0d",
               got.kind, got.target, got.now);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.target !== want.target) begin
        $error("target: expected %0d, got %0d", want.target, got.target);
        errors++;
      end
      if (got.from_sector !== want.from_sector) begin
        $error("from_sector: expected %0d, got %0d", want.from_sector, got.from_sector);
        errors++;
      end
      if (got.now !== want.now) begin
        $error("now: expected %0d, got %0d", want.now, got.now);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  sstf_pkg::in_item_t  in_data = '0;
  logic                busy;
  logic                out_valid;
  sstf_pkg::out_item_t out_data;

  seek_scoreboard sb;
  int             stall_cycles = 0;
  logic           no_idle      = 1'b0;

  sstf_disk_head_scheduler_unit #(
    .DEPTH      (SLOTS),
    .SECTOR_BITS(SEC_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_event(out_data);
  end

  // Any cycle without a transfer on either side counts toward the stall limit.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Start stays high across back-to-back items, so it is lowered only for a gap.
  task automatic send_item(sstf_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.log_request(it);
  endtask

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int items_sent();
    return sb.n_ticks + sb.n_arrivals + sb.n_dropped;
  endfunction

  task automatic send_tick(int gap);
    sstf_pkg::in_item_t it;
    it.func   = sstf_pkg::FUNC_TICK;
    it.sector = logic'($urandom_range(0, 1)) ? SEC_W'($urandom) : '0;
    send_item(it, gap);
  endtask

  task automatic send_arrival(int sector, int gap);
    sstf_pkg::in_item_t it;
    it.func   = sstf_pkg::FUNC_ARRIVAL;
    it.sector = SEC_W'(sector);
    send_item(it, gap);
  endtask

  // Run ticks back to back until the current seek is nearly over.
  task automatic drain_seek(int leave);
    while (sb.head_busy && sb.seek_remaining > leave && items_sent() < NUM_ITEMS)
      send_tick(0);
  endtask

  initial begin
    int h;
    int s;
    int n;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, zero-length seek at the home position, then a
    // long seek behind which the table fills up.
    send_tick(pick_gap());
    send_arrival(0, pick_gap());
    send_arrival(200, pick_gap());
    for (int i = 0; i < SLOTS; i++) send_arrival(200 - (i % 5), pick_gap());
    send_arrival(SEC_MAX, pick_gap());
    // The final tick completes the long seek and cascades through all 16
    // seeks shorter than one step.
    drain_seek(0);

    // Two requests at equal distance from a seek target: the lower slot wins.
    h = int'(sb.head_at);
    send_arrival(h - 25, pick_gap());
    send_arrival(h - 28, pick_gap());
    send_arrival(h - 22, pick_gap());
    repeat (6) send_tick(pick_gap());

    // Random: mostly arrivals close to the head so that seeks stay short,
    // with occasional farther requests that force longer seeks and drops.
    n = 0;
    while (items_sent() < NUM_ITEMS) begin
      if (n % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 45) begin
        send_tick(pick_gap());
      end else begin
        if ($urandom_range(0, 99) < 7) begin
          s = int'(sb.head_at) + int'($urandom_range(0, 1200)) - 600;
        end else begin
          s = int'(sb.head_at) + $urandom_range(0, 80) - 40;
        end
        if (s < 0) s = 0;
        if (s > SEC_MAX) s = SEC_MAX;
        send_arrival(s, pick_gap());
      end
      if (sb.head_busy && sb.seek_remaining > 30 && $urandom_range(0, 2) == 0)
        drain_seek($urandom_range(0, 10));
      n++;
    end
    start <= 1'b0;

    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending_events.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_events.size());
      sb.errors++;
    end
    $display("Run covered %0d ticks, %0d accepted and %0d dropped arrivals,",
             sb.n_ticks, sb.n_arrivals, sb.n_dropped);
    $display("%0d completed seeks and %0d results compared field by field.",
             sb.n_done, sb.n_checked);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
